### hdl/qmn_pkg.sv
// Shared types and constants for the quadtree Morton navigation unit.
// No dependencies; imported by quadtree_morton_navigation_unit.
package qmn_pkg;

    localparam int COORD_BITS = 30;
    localparam int MAX_LEVEL  = 29;
    localparam int LVL_W      = 5;

    typedef enum logic [1:0] {
        OP_CHILD   = 2'd0,
        OP_PARENT  = 2'd1,
        OP_SIBLING = 2'd2,
        OP_SUCC    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_PAST_END = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t                 opcode;
        logic [COORD_BITS-1:0]   in_x;
        logic [COORD_BITS-1:0]   in_y;
        logic [LVL_W-1:0]        in_level;
        logic [1:0]              which_child;
        logic [LVL_W-1:0]        target_level;
        logic                    multilevel;
    } cmd_t;

    typedef struct packed {
        logic [COORD_BITS-1:0]   out_x;
        logic [COORD_BITS-1:0]   out_y;
        logic [LVL_W-1:0]        out_level;
        status_t                 status;
    } result_t;

endpackage

### hdl/quadtree_morton_navigation_unit.sv
// Quadtree cell navigation in Morton order: child, parent, sibling, successor.
// Depends on qmn_pkg for the command and result word types.

// A command word is taken on every clock edge where start is high; busy is
// never raised, so one word per cycle is sustained. Each result word appears
// on result for one cycle with done high, in command order, after passing
// through three register stages: decode and alignment check, successor climb
// search (a carry chain across the ANDed coordinate bits), and level encode
// with final select. The receiver cannot stall the pipeline, so results must
// be taken when shown.
module quadtree_morton_navigation_unit
    import qmn_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    done,
    output result_t result
);

    localparam int HW = COORD_BITS + 1;

    // ---------------- stage 1: decode ----------------
    logic                  s1_valid_reg;
    cmd_t                  s1_cmd_reg;
    logic                  s1_bad_reg;
    logic [HW-1:0]         s1_hl_reg;
    logic [COORD_BITS-1:0] s1_and_reg;

    logic [HW-1:0]         hl_next;
    logic [HW-1:0]         lowmask;
    logic                  lvl_ok;
    logic                  bad_next;
    logic [COORD_BITS-1:0] and_next;

    // Build the cell length bit and check level and alignment
    always_comb
    begin
        lvl_ok   = (cmd.in_level <= LVL_W'(MAX_LEVEL)) &&
                   (cmd.in_level < LVL_W'(COORD_BITS));
        hl_next  = HW'(1) << (LVL_W'(COORD_BITS) - cmd.in_level);
        lowmask  = hl_next - HW'(1);
        bad_next = !lvl_ok ||
                   (((cmd.in_x | cmd.in_y) & lowmask[COORD_BITS-1:0]) != '0);
        // force bits below the cell length to one so the climb skips them
        and_next = (cmd.in_x & cmd.in_y) | lowmask[COORD_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg <= cmd;
        s1_bad_reg <= bad_next;
        s1_hl_reg  <= hl_next;
        s1_and_reg <= and_next;
    end

    // ---------------- stage 2: direct ops and climb search ----------------
    logic                  s2_valid_reg;
    result_t               s2_res_reg;
    logic                  s2_climb_reg;
    logic [COORD_BITS-1:0] s2_x_reg;
    logic [COORD_BITS-1:0] s2_y_reg;
    logic [COORD_BITS-1:0] s2_keep_reg;
    logic [COORD_BITS-1:0] s2_hot_reg;
    logic                  s2_past_reg;
    logic [LVL_W-1:0]      s2_tgt_reg;
    logic                  s2_multi_reg;

    result_t               res_next;
    logic                  climb_next;
    logic [HW-1:0]         inc;
    logic [HW-1:0]         flip;
    logic [COORD_BITS-1:0] hc;
    logic [COORD_BITS-1:0] hp;
    logic [LVL_W:0]        lvl_p1;
    logic                  tgt_ok;

    always_comb
    begin
        inc    = {1'b0, s1_and_reg} + HW'(1);
        flip   = {1'b0, s1_and_reg} ^ inc;
        hc     = s1_hl_reg[COORD_BITS:1];
        hp     = s1_hl_reg[COORD_BITS-1:0];
        lvl_p1 = {1'b0, s1_cmd_reg.in_level} + (LVL_W+1)'(1);
        tgt_ok = (s1_cmd_reg.target_level <= LVL_W'(MAX_LEVEL)) &&
                 (s1_cmd_reg.target_level < LVL_W'(COORD_BITS));

        res_next.out_x     = s1_cmd_reg.in_x;
        res_next.out_y     = s1_cmd_reg.in_y;
        res_next.out_level = s1_cmd_reg.in_level;
        res_next.status    = ST_OK;
        climb_next         = 1'b0;

        if (s1_bad_reg)
        begin
            res_next.status = ST_INVALID;
        end
        else
        begin
            case (s1_cmd_reg.opcode)
                OP_CHILD:
                begin
                    if ((s1_cmd_reg.in_level >= LVL_W'(MAX_LEVEL)) ||
                        (lvl_p1 >= (LVL_W+1)'(COORD_BITS)))
                    begin
                        res_next.status = ST_INVALID;
                    end
                    else
                    begin
                        if (s1_cmd_reg.which_child[0])
                        begin
                            res_next.out_x = s1_cmd_reg.in_x | hc;
                        end
                        if (s1_cmd_reg.which_child[1])
                        begin
                            res_next.out_y = s1_cmd_reg.in_y | hc;
                        end
                        res_next.out_level = lvl_p1[LVL_W-1:0];
                    end
                end
                OP_PARENT, OP_SIBLING:
                begin
                    if (s1_cmd_reg.in_level == '0)
                    begin
                        res_next.status = ST_INVALID;
                    end
                    else
                    begin
                        res_next.out_x = s1_cmd_reg.in_x & ~hp;
                        res_next.out_y = s1_cmd_reg.in_y & ~hp;
                        if (s1_cmd_reg.opcode == OP_PARENT)
                        begin
                            res_next.out_level = s1_cmd_reg.in_level - LVL_W'(1);
                        end
                        else
                        begin
                            if (s1_cmd_reg.which_child[0])
                            begin
                                res_next.out_x = res_next.out_x | hp;
                            end
                            if (s1_cmd_reg.which_child[1])
                            begin
                                res_next.out_y = res_next.out_y | hp;
                            end
                        end
                    end
                end
                default:
                begin
                    if (!tgt_ok || (s1_cmd_reg.target_level < s1_cmd_reg.in_level))
                    begin
                        res_next.status = ST_INVALID;
                    end
                    else if (s1_cmd_reg.in_level < s1_cmd_reg.target_level)
                    begin
                        // descend to child 0, or straight to the target
                        res_next.out_level = s1_cmd_reg.multilevel ?
                                             lvl_p1[LVL_W-1:0] :
                                             s1_cmd_reg.target_level;
                    end
                    else
                    begin
                        climb_next = 1'b1;
                    end
                end
            endcase
        end

        // zero the fields of an error word
        if (res_next.status != ST_OK)
        begin
            res_next.out_x     = '0;
            res_next.out_y     = '0;
            res_next.out_level = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_res_reg   <= res_next;
        s2_climb_reg <= climb_next;
        s2_x_reg     <= s1_cmd_reg.in_x;
        s2_y_reg     <= s1_cmd_reg.in_y;
        s2_keep_reg  <= ~flip[COORD_BITS-1:0];
        s2_hot_reg   <= flip[COORD_BITS-1:0] & inc[COORD_BITS-1:0];
        s2_past_reg  <= inc[COORD_BITS];
        s2_tgt_reg   <= s1_cmd_reg.target_level;
        s2_multi_reg <= s1_cmd_reg.multilevel;
    end

    // ---------------- stage 3: encode climb level and select ----------------
    logic              done_reg;
    result_t           result_reg;
    result_t           result_next;
    logic [LVL_W-1:0]  enc;

    always_comb
    begin
        enc = '0;
        for (int b = 0; b < COORD_BITS; b++)
        begin
            if (s2_hot_reg[b])
            begin
                enc = enc | LVL_W'(COORD_BITS - b);
            end
        end

        result_next = s2_res_reg;
        if (s2_climb_reg)
        begin
            if (s2_past_reg)
            begin
                result_next.out_x     = '0;
                result_next.out_y     = '0;
                result_next.out_level = '0;
                result_next.status    = ST_PAST_END;
            end
            else
            begin
                // step to the next sibling at the first non-last ancestor
                result_next.out_x = (s2_x_reg & s2_keep_reg) | (s2_hot_reg & ~s2_x_reg);
                result_next.out_y = (s2_y_reg & s2_keep_reg) |
                                    (s2_hot_reg & (s2_x_reg | s2_y_reg));
                result_next.out_level = (!s2_multi_reg && (enc < s2_tgt_reg)) ?
                                        s2_tgt_reg : enc;
                result_next.status    = ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // Drive outputs
    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

### sim/testbench.sv
// Self-checking bench for quadtree_morton_navigation_unit: directed table plus random cells.
// Depends on qmn_pkg (command and result word types) and the unit itself.
`timescale 1ns / 100ps

module testbench;
    import qmn_pkg::*;

    localparam int          RANDOM_WORDS   = 500;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          PRINT_LIMIT    = 100;
    localparam logic [1:0]  LAST_CHILD     = 2'd3;

    // One row of the directed table: a command word, and its result where typed in
    typedef struct {
        cmd_t    word;
        bit      fixed;
        result_t res;
    } vector_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    done;
    result_t result;

    // Typed-in result travels beside the command word it belongs to
    logic    fixed_valid;
    result_t fixed_res;

    result_t expected_q[$];
    result_t want_res;
    vector_t directed[$];
    int      mismatch_count;
    int      idle_cycles;

    quadtree_morton_navigation_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic bit level_fits(int lvl);
        return lvl <= MAX_LEVEL && lvl < COORD_BITS;
    endfunction

    function automatic logic [63:0] cell_size(int lvl);
        return 64'd1 << (COORD_BITS - lvl);
    endfunction

    // Child id of a cell within its parent: x bit low, y bit high, zero at the root
    function automatic logic [1:0] quadrant(logic [63:0] x, logic [63:0] y, int lvl);
        logic [63:0] h;
        if (lvl == 0)
            return 2'd0;
        h = cell_size(lvl);
        return {(y & h) != 0, (x & h) != 0};
    endfunction

    // Expected result word for one command word
    function automatic result_t predict_cell(cmd_t c);
        result_t     r;
        logic [63:0] x, y, h, keep, rx, ry;
        int          lvl, tgt, l, rl;
        logic [1:0]  nid;
        status_t     st;
        x   = 64'(c.in_x);
        y   = 64'(c.in_y);
        lvl = int'(c.in_level);
        tgt = int'(c.target_level);
        rx  = '0;
        ry  = '0;
        rl  = 0;
        st  = ST_OK;
        if (!level_fits(lvl))
            st = ST_INVALID;
        else if (((x | y) & (cell_size(lvl) - 1)) != 0)
            st = ST_INVALID;
        else
        begin
            case (c.opcode)
                OP_CHILD:
                begin
                    if (lvl >= MAX_LEVEL || lvl + 1 >= COORD_BITS)
                        st = ST_INVALID;
                    else
                    begin
                        h  = cell_size(lvl + 1);
                        rx = c.which_child[0] ? (x | h) : x;
                        ry = c.which_child[1] ? (y | h) : y;
                        rl = lvl + 1;
                    end
                end
                OP_PARENT, OP_SIBLING:
                begin
                    if (lvl == 0)
                        st = ST_INVALID;
                    else
                    begin
                        h  = cell_size(lvl);
                        rx = x & ~h;
                        ry = y & ~h;
                        if (c.opcode == OP_PARENT)
                            rl = lvl - 1;
                        else
                        begin
                            if (c.which_child[0])
                                rx = rx | h;
                            if (c.which_child[1])
                                ry = ry | h;
                            rl = lvl;
                        end
                    end
                end
                default:
                begin
                    if (!level_fits(tgt) || tgt < lvl)
                        st = ST_INVALID;
                    else if (lvl < tgt)
                    begin
                        // descend into child 0
                        rx = x;
                        ry = y;
                        rl = lvl + 1;
                    end
                    else
                    begin
                        // climb past last siblings, then step to the next one
                        l = lvl;
                        while (l > 0 && quadrant(x, y, l) == LAST_CHILD)
                            l--;
                        if (l == 0)
                            st = ST_PAST_END;
                        else
                        begin
                            h    = cell_size(l);
                            nid  = quadrant(x, y, l) + 2'd1;
                            keep = ~((h << 1) - 1);
                            rx   = (x & keep) | (nid[0] ? h : 64'd0);
                            ry   = (y & keep) | (nid[1] ? h : 64'd0);
                            rl   = l;
                        end
                    end
                    if (st == ST_OK && !c.multilevel && rl < tgt)
                        rl = tgt;
                end
            endcase
        end
        r = '0;
        r.status = st;
        if (st == ST_OK)
        begin
            r.out_x     = rx[COORD_BITS-1:0];
            r.out_y     = ry[COORD_BITS-1:0];
            r.out_level = rl[LVL_W-1:0];
        end
        return r;
    endfunction

    function automatic cmd_t make_cmd(opcode_t op, logic [29:0] x, logic [29:0] y,
                                      logic [4:0] lvl, logic [1:0] wc, logic [4:0] tgt,
                                      logic ml);
        cmd_t c;
        c.opcode       = op;
        c.in_x         = x;
        c.in_y         = y;
        c.in_level     = lvl;
        c.which_child  = wc;
        c.target_level = tgt;
        c.multilevel   = ml;
        return c;
    endfunction

    function automatic vector_t checked_row(cmd_t c);
        vector_t v;
        v.word  = c;
        v.fixed = 1'b0;
        v.res   = '0;
        return v;
    endfunction

    function automatic vector_t typed_row(cmd_t c, logic [29:0] rx, logic [29:0] ry,
                                          logic [4:0] rl, status_t st);
        vector_t v;
        v.word          = c;
        v.fixed         = 1'b1;
        v.res.out_x     = rx;
        v.res.out_y     = ry;
        v.res.out_level = rl;
        v.res.status    = st;
        return v;
    endfunction

    // Random cell, mostly well formed, with coordinates biased toward last siblings
    function automatic cmd_t random_cell();
        cmd_t        c;
        logic [63:0] x, y, ones;
        int          lvl, k;
        c.opcode      = opcode_t'($urandom_range(0, 3));
        c.which_child = 2'($urandom_range(0, 3));
        c.multilevel  = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 15) == 0)
            lvl = $urandom_range(0, 31);
        else
            lvl = $urandom_range(0, 29);
        x = 64'($urandom);
        y = 64'($urandom);
        case ($urandom_range(0, 3))
            0:
            begin
                x = '1;
                y = '1;
            end
            1:
            begin
                k    = $urandom_range(0, 30);
                ones = (64'd1 << k) - 1;
                x    = x | ones;
                y    = y | ones;
            end
            default:
            begin
            end
        endcase
        if (lvl <= COORD_BITS && $urandom_range(0, 15) != 0)
        begin
            x = x & ~(cell_size(lvl) - 1);
            y = y & ~(cell_size(lvl) - 1);
        end
        c.in_x     = x[COORD_BITS-1:0];
        c.in_y     = y[COORD_BITS-1:0];
        c.in_level = lvl[LVL_W-1:0];
        if ($urandom_range(0, 15) == 0 || lvl > MAX_LEVEL)
            c.target_level = 5'($urandom_range(0, 31));
        else
            c.target_level = 5'($urandom_range(lvl, MAX_LEVEL));
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want_v);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h",
                     $realtime, what, got, want_v);
    endtask

    // Present one command word after a gap and hold it until it is taken
    task automatic issue_word(input cmd_t c, input bit fixed, input result_t res, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        cmd         <= c;
        fixed_valid <= fixed;
        fixed_res   <= res;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Hold off the sender until every expected result word has come back
    task automatic drain_results();
        start <= 1'b0;
        do
            @(negedge clk);
        while (expected_q.size() != 0);
        @(posedge clk);
    endtask

    // Check the word leaving the block, log the word entering it, and watch for hangs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("result with nothing pending", 64'(result.status), '0);
                else
                begin
                    want_res = expected_q.pop_front();
                    if (result.out_x !== want_res.out_x)
                        report_mismatch("out_x", 64'(result.out_x), 64'(want_res.out_x));
                    if (result.out_y !== want_res.out_y)
                        report_mismatch("out_y", 64'(result.out_y), 64'(want_res.out_y));
                    if (result.out_level !== want_res.out_level)
                        report_mismatch("out_level", 64'(result.out_level),
                                        64'(want_res.out_level));
                    if (result.status !== want_res.status)
                        report_mismatch("status", 64'(result.status), 64'(want_res.status));
                end
            end
            if (start && !busy)
                expected_q.push_back(fixed_valid ? fixed_res : predict_cell(cmd));
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int gap;
        rst_n          = 1'b0;
        start          = 1'b0;
        cmd            = '0;
        fixed_valid    = 1'b0;
        fixed_res      = '0;
        mismatch_count = 0;
        idle_cycles    = 0;

        // Directed table: extremes, every opcode, every error path
        directed.push_back(typed_row(make_cmd(OP_CHILD, 30'h0, 30'h0, 5'd0, 2'd3, 5'd0, 1'b0),
                                     30'h2000_0000, 30'h2000_0000, 5'd1, ST_OK));
        directed.push_back(typed_row(make_cmd(OP_PARENT, 30'h0, 30'h0, 5'd0, 2'd0, 5'd0, 1'b0),
                                     30'h0, 30'h0, 5'd0, ST_INVALID));
        directed.push_back(typed_row(make_cmd(OP_SIBLING, 30'h0, 30'h0, 5'd0, 2'd3, 5'd0, 1'b1),
                                     30'h0, 30'h0, 5'd0, ST_INVALID));
        directed.push_back(typed_row(make_cmd(OP_CHILD, 30'h0, 30'h0, 5'd30, 2'd0, 5'd30, 1'b0),
                                     30'h0, 30'h0, 5'd0, ST_INVALID));
        directed.push_back(typed_row(make_cmd(OP_SUCC, 30'h0, 30'h0, 5'd31, 2'd0, 5'd31, 1'b1),
                                     30'h0, 30'h0, 5'd0, ST_INVALID));
        directed.push_back(typed_row(make_cmd(OP_PARENT, 30'h1, 30'h0, 5'd1, 2'd0, 5'd1, 1'b0),
                                     30'h0, 30'h0, 5'd0, ST_INVALID));
        directed.push_back(typed_row(make_cmd(OP_CHILD, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 5'd0,
                                              2'd0, 5'd0, 1'b0),
                                     30'h0, 30'h0, 5'd0, ST_INVALID));
        directed.push_back(typed_row(make_cmd(OP_CHILD, 30'h0, 30'h0, 5'd29, 2'd1, 5'd29, 1'b0),
                                     30'h0, 30'h0, 5'd0, ST_INVALID));
        directed.push_back(checked_row(make_cmd(OP_CHILD, 30'h3FFF_FFFC, 30'h3FFF_FFFC, 5'd28,
                                                2'd3, 5'd28, 1'b0)));
        directed.push_back(checked_row(make_cmd(OP_PARENT, 30'h3FFF_FFFE, 30'h3FFF_FFFE, 5'd29,
                                                2'd0, 5'd29, 1'b0)));
        directed.push_back(checked_row(make_cmd(OP_SIBLING, 30'h2000_0000, 30'h0, 5'd1,
                                                2'd2, 5'd1, 1'b0)));
        directed.push_back(checked_row(make_cmd(OP_SIBLING, 30'h3FFF_FFFE, 30'h0, 5'd29,
                                                2'd1, 5'd0, 1'b1)));
        directed.push_back(typed_row(make_cmd(OP_SUCC, 30'h0, 30'h0, 5'd5, 2'd0, 5'd4, 1'b0),
                                     30'h0, 30'h0, 5'd0, ST_INVALID));
        directed.push_back(typed_row(make_cmd(OP_SUCC, 30'h0, 30'h0, 5'd0, 2'd0, 5'd30, 1'b0),
                                     30'h0, 30'h0, 5'd0, ST_INVALID));
        directed.push_back(typed_row(make_cmd(OP_SUCC, 30'h0, 30'h0, 5'd0, 2'd0, 5'd0, 1'b0),
                                     30'h0, 30'h0, 5'd0, ST_PAST_END));
        directed.push_back(typed_row(make_cmd(OP_SUCC, 30'h3FFF_FFFE, 30'h3FFF_FFFE, 5'd29,
                                              2'd0, 5'd29, 1'b1),
                                     30'h0, 30'h0, 5'd0, ST_PAST_END));
        directed.push_back(checked_row(make_cmd(OP_SUCC, 30'h0, 30'h0, 5'd0, 2'd0, 5'd29, 1'b0)));
        directed.push_back(checked_row(make_cmd(OP_SUCC, 30'h0, 30'h0, 5'd0, 2'd0, 5'd5, 1'b1)));
        directed.push_back(checked_row(make_cmd(OP_SUCC, 30'h1000_0000, 30'h1000_0000, 5'd2,
                                                2'd0, 5'd2, 1'b0)));
        directed.push_back(checked_row(make_cmd(OP_SUCC, 30'h1000_0000, 30'h1000_0000, 5'd2,
                                                2'd0, 5'd2, 1'b1)));
        directed.push_back(checked_row(make_cmd(OP_SUCC, 30'h2, 30'h0, 5'd29, 2'd0, 5'd29, 1'b0)));
        directed.push_back(checked_row(make_cmd(OP_SUCC, 30'h3FFF_FFFE, 30'h1FFF_FFFE, 5'd29,
                                                2'd3, 5'd29, 1'b0)));

        // Hold reset, then release it at a clock edge
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (directed[i])
            issue_word(directed[i].word, directed[i].fixed, directed[i].res,
                       $urandom_range(0, 3));

        // Random words; every other block of 50 runs back to back
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS / 2)
                drain_results();
            gap = ((i / 50) % 2 == 1) ? 0 : $urandom_range(0, 3);
            issue_word(random_cell(), 1'b0, '0, gap);
        end

        // Let the pipeline empty, then give the verdict
        drain_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
